FILE: hw/rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, constants and controller/datapath interface structs for the
// static linked-list pool.
// ----------------------------------------------------------------------------
package slp_pkg;

    // pool geometry
    localparam int NODES = 128;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int CMP_W = CNT_W + 1;

    // field widths at the ports
    localparam int KIND_W   = 3;
    localparam int NODE_W   = 7;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW    = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_GET    = 3'd3,
        KIND_LENGTH = 3'd4,
        KIND_CLEAR  = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_RANGE     = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_EXHAUSTED = 2'd3
    } status_code_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_LEN_WALK,
        S_STEP_WALK,
        S_GET_A,
        S_NEW_A,
        S_NEW_B,
        S_NEW_C,
        S_INS_A,
        S_INS_B,
        S_INS_C,
        S_INS_WALK,
        S_INS_D,
        S_DEL_A,
        S_DEL_B,
        S_DEL_C,
        S_DEL_D,
        S_CLR_A,
        S_CLR_B,
        S_CLR_C,
        S_CLR_D,
        S_TAIL_WALK,
        S_DONE
    } state_t;

    // link memory read address source
    typedef enum logic [1:0] {
        RA_LINK,
        RA_ZERO,
        RA_HEAD,
        RA_J
    } ra_sel_t;

    // link memory write address source
    typedef enum logic [2:0] {
        WA_ZERO,
        WA_HEAD,
        WA_J,
        WA_K,
        WA_CUR,
        WA_CNT
    } wa_sel_t;

    // link memory write data source
    typedef enum logic [2:0] {
        WD_ZERO,
        WD_LINK,
        WD_J,
        WD_K,
        WD_INIT
    } wd_sel_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_HEAD,
        CUR_J,
        CUR_LINK
    } cur_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC
    } cnt_op_t;

    typedef struct packed {
        logic         load_req;
        ra_sel_t      ra_sel;
        logic         nx_we;
        wa_sel_t      wa_sel;
        wd_sel_t      wd_sel;
        logic         val_we;
        cur_sel_t     cur_sel;
        cnt_op_t      cnt_op;
        logic         j_load;
        logic         k_load;
        logic         set_status;
        status_code_t status_code;
        logic         set_new_head;
        logic         set_length;
        logic         set_read;
        logic         publish;
    } slp_cmd_t;

    typedef struct packed {
        logic link_zero;
        logic cnt_full;
        logic cnt_zero;
        logic init_last;
        logic head_bad;
        logic pos_zero;
        logic pos_gt_len;
        logic pos_gt_len1;
        logic cnt_eq_pos;
        logic cnt_eq_posm1;
    } slp_sts_t;

endpackage

FILE: hw/rtl/slp_ram.sv
// ----------------------------------------------------------------------------
// slp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/slp_dpath.sv
// ----------------------------------------------------------------------------
// slp_dpath
// Datapath: link and value memories, walk cursor and counter, request and
// result registers.
// ----------------------------------------------------------------------------
module slp_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  slp_pkg::slp_cmd_t                   cmd,
    output slp_pkg::slp_sts_t                   sts,
    input  logic [slp_pkg::NODE_W-1:0]          list_head,
    input  logic [slp_pkg::POS_W-1:0]           position,
    input  logic signed [slp_pkg::VALUE_W-1:0]  value,
    output logic [slp_pkg::STATUS_W-1:0]        status,
    output logic [slp_pkg::NODE_W-1:0]          new_head,
    output logic signed [slp_pkg::VALUE_W-1:0]  read_value,
    output logic [slp_pkg::LEN_W-1:0]           length
);

    localparam logic [slp_pkg::LEN_W-1:0] LEN_MAX = {slp_pkg::LEN_W{1'b1}};

    logic [slp_pkg::IDX_W-1:0]   head_reg;
    logic [slp_pkg::POS_W-1:0]   pos_reg;
    logic [slp_pkg::VALUE_W-1:0] val_reg;
    logic [slp_pkg::IDX_W-1:0]   cur_reg;
    logic [slp_pkg::IDX_W-1:0]   cur_next;
    logic [slp_pkg::IDX_W-1:0]   j_reg;
    logic [slp_pkg::IDX_W-1:0]   k_reg;
    logic [slp_pkg::CNT_W-1:0]   cnt_reg;
    logic [slp_pkg::CNT_W-1:0]   cnt_next;

    logic [slp_pkg::IDX_W-1:0]   link;
    logic [slp_pkg::IDX_W-1:0]   nx_raddr;
    logic [slp_pkg::IDX_W-1:0]   nx_waddr;
    logic [slp_pkg::IDX_W-1:0]   nx_wdata;
    logic [slp_pkg::IDX_W-1:0]   init_data;
    logic [slp_pkg::VALUE_W-1:0] val_rdata;
    logic [slp_pkg::LEN_W-1:0]   len_sat;

    slp_pkg::status_code_t       res_status_reg;
    logic [slp_pkg::NODE_W-1:0]  res_new_head_reg;
    logic [slp_pkg::VALUE_W-1:0] res_read_reg;
    logic [slp_pkg::LEN_W-1:0]   res_len_reg;
    slp_pkg::status_code_t       out_status_reg;
    logic [slp_pkg::NODE_W-1:0]  out_new_head_reg;
    logic [slp_pkg::VALUE_W-1:0] out_read_reg;
    logic [slp_pkg::LEN_W-1:0]   out_len_reg;

    // link memory: next index of every node
    slp_ram #(
        .WIDTH (slp_pkg::IDX_W),
        .DEPTH (slp_pkg::NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (cmd.nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (link)
    );

    // value memory, always read at the cursor
    slp_ram #(
        .WIDTH (slp_pkg::VALUE_W),
        .DEPTH (slp_pkg::NODES)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.val_we),
        .waddr (j_reg),
        .wdata (val_reg),
        .raddr (cur_reg),
        .rdata (val_rdata)
    );

    // reset sweep writes i+1, wrapping to 0 on the last node
    assign init_data = (cnt_reg == slp_pkg::CNT_W'(slp_pkg::NODES - 1)) ? '0
                     : slp_pkg::IDX_W'(cnt_reg + slp_pkg::CNT_W'(1));

    always_comb
    begin
        case (cmd.ra_sel)
            slp_pkg::RA_ZERO: nx_raddr = '0;
            slp_pkg::RA_HEAD: nx_raddr = head_reg;
            slp_pkg::RA_J:    nx_raddr = j_reg;
            default:          nx_raddr = link;
        endcase
    end

    always_comb
    begin
        case (cmd.wa_sel)
            slp_pkg::WA_ZERO: nx_waddr = '0;
            slp_pkg::WA_HEAD: nx_waddr = head_reg;
            slp_pkg::WA_J:    nx_waddr = j_reg;
            slp_pkg::WA_K:    nx_waddr = k_reg;
            slp_pkg::WA_CUR:  nx_waddr = cur_reg;
            default:          nx_waddr = cnt_reg[slp_pkg::IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        case (cmd.wd_sel)
            slp_pkg::WD_ZERO: nx_wdata = '0;
            slp_pkg::WD_LINK: nx_wdata = link;
            slp_pkg::WD_J:    nx_wdata = j_reg;
            slp_pkg::WD_K:    nx_wdata = k_reg;
            default:          nx_wdata = init_data;
        endcase
    end

    always_comb
    begin
        case (cmd.cur_sel)
            slp_pkg::CUR_HEAD: cur_next = head_reg;
            slp_pkg::CUR_J:    cur_next = j_reg;
            slp_pkg::CUR_LINK: cur_next = link;
            default:           cur_next = cur_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            slp_pkg::CNT_CLEAR: cnt_next = '0;
            slp_pkg::CNT_INC:   cnt_next = cnt_reg + slp_pkg::CNT_W'(1);
            default:            cnt_next = cnt_reg;
        endcase
    end

    assign len_sat = (cnt_reg > slp_pkg::CNT_W'(LEN_MAX)) ? LEN_MAX
                   : slp_pkg::LEN_W'(cnt_reg);

    // status toward the controller
    always_comb
    begin
        sts.link_zero    = (link == '0);
        sts.cnt_full     = (cnt_reg == slp_pkg::CNT_W'(slp_pkg::NODES));
        sts.cnt_zero     = (cnt_reg == '0);
        sts.init_last    = (cnt_reg == slp_pkg::CNT_W'(slp_pkg::NODES - 1));
        sts.head_bad     = (head_reg == '0)
                        || (int'(head_reg) >= slp_pkg::NODES);
        sts.pos_zero     = (pos_reg == '0);
        sts.pos_gt_len   = (slp_pkg::CMP_W'(pos_reg) > slp_pkg::CMP_W'(cnt_reg));
        sts.pos_gt_len1  = (slp_pkg::CMP_W'(pos_reg)
                            > slp_pkg::CMP_W'(cnt_reg) + slp_pkg::CMP_W'(1));
        sts.cnt_eq_pos   = (slp_pkg::CMP_W'(cnt_reg) == slp_pkg::CMP_W'(pos_reg));
        sts.cnt_eq_posm1 = (slp_pkg::CMP_W'(cnt_reg) + slp_pkg::CMP_W'(1)
                            == slp_pkg::CMP_W'(pos_reg));
    end

    // counter doubles as the reset sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.j_load)
        begin
            j_reg <= link;
        end
        if (cmd.k_load)
        begin
            k_reg <= link;
        end
        if (cmd.load_req)
        begin
            head_reg         <= slp_pkg::IDX_W'(list_head);
            pos_reg          <= position;
            val_reg          <= value;
            res_status_reg   <= slp_pkg::STS_OK;
            res_new_head_reg <= '0;
            res_read_reg     <= '0;
            res_len_reg      <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.set_new_head)
            begin
                res_new_head_reg <= slp_pkg::NODE_W'(j_reg);
            end
            if (cmd.set_read)
            begin
                res_read_reg <= val_rdata;
            end
            if (cmd.set_length)
            begin
                res_len_reg <= len_sat;
            end
        end
        if (cmd.publish)
        begin
            out_status_reg   <= res_status_reg;
            out_new_head_reg <= res_new_head_reg;
            out_read_reg     <= res_read_reg;
            out_len_reg      <= res_len_reg;
        end
    end

    assign status     = out_status_reg;
    assign new_head   = out_new_head_reg;
    assign read_value = out_read_reg;
    assign length     = out_len_reg;

endmodule

FILE: hw/rtl/slp_ctrl.sv
// ----------------------------------------------------------------------------
// slp_ctrl
// Controller: sequences reset sweep, chain walks and link updates for each
// request, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module slp_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [slp_pkg::KIND_W-1:0]   kind,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  slp_pkg::slp_sts_t            sts,
    output slp_pkg::slp_cmd_t            cmd
);

    slp_pkg::state_t state_reg;
    slp_pkg::state_t state_next;
    slp_pkg::kind_t  kind_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accept;
    logic            walk_more;
    logic            at_target;
    logic            out_free;

    assign accept    = in_valid && (state_reg == slp_pkg::S_IDLE);
    assign walk_more = !sts.link_zero && !sts.cnt_full;
    assign at_target = (kind_reg == slp_pkg::KIND_GET) ? sts.cnt_eq_pos
                                                        : sts.cnt_eq_posm1;
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slp_pkg::S_INIT:
            begin
                if (sts.init_last)
                begin
                    state_next = slp_pkg::S_IDLE;
                end
            end
            slp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = slp_pkg::S_DISPATCH;
                end
            end
            slp_pkg::S_DISPATCH:
            begin
                case (kind_reg)
                    slp_pkg::KIND_NEW:
                        state_next = slp_pkg::S_NEW_A;
                    slp_pkg::KIND_INSERT, slp_pkg::KIND_DELETE,
                    slp_pkg::KIND_GET, slp_pkg::KIND_LENGTH:
                        state_next = sts.head_bad ? slp_pkg::S_DONE : slp_pkg::S_LEN_WALK;
                    slp_pkg::KIND_CLEAR:
                        state_next = sts.head_bad ? slp_pkg::S_DONE : slp_pkg::S_CLR_A;
                    default:
                        state_next = slp_pkg::S_DONE;
                endcase
            end
            slp_pkg::S_LEN_WALK:
            begin
                if (!walk_more)
                begin
                    case (kind_reg)
                        slp_pkg::KIND_INSERT:
                            state_next = (sts.pos_zero || sts.pos_gt_len1)
                                       ? slp_pkg::S_DONE : slp_pkg::S_INS_A;
                        slp_pkg::KIND_DELETE, slp_pkg::KIND_GET:
                            state_next = sts.cnt_zero ||
                                         sts.pos_zero || sts.pos_gt_len
                                       ? slp_pkg::S_DONE : slp_pkg::S_STEP_WALK;
                        default:
                            state_next = slp_pkg::S_DONE;
                    endcase
                end
            end
            slp_pkg::S_STEP_WALK:
            begin
                if (at_target)
                begin
                    state_next = (kind_reg == slp_pkg::KIND_GET) ? slp_pkg::S_GET_A
                                                                  : slp_pkg::S_DEL_A;
                end
            end
            slp_pkg::S_GET_A:     state_next = slp_pkg::S_DONE;
            slp_pkg::S_NEW_A:
                state_next = sts.link_zero ? slp_pkg::S_DONE : slp_pkg::S_NEW_B;
            slp_pkg::S_NEW_B:     state_next = slp_pkg::S_NEW_C;
            slp_pkg::S_NEW_C:     state_next = slp_pkg::S_DONE;
            slp_pkg::S_INS_A:
                state_next = sts.link_zero ? slp_pkg::S_DONE : slp_pkg::S_INS_B;
            slp_pkg::S_INS_B:     state_next = slp_pkg::S_INS_C;
            slp_pkg::S_INS_C:     state_next = slp_pkg::S_INS_WALK;
            slp_pkg::S_INS_WALK:
            begin
                if (sts.cnt_eq_posm1)
                begin
                    state_next = slp_pkg::S_INS_D;
                end
            end
            slp_pkg::S_INS_D:     state_next = slp_pkg::S_DONE;
            slp_pkg::S_DEL_A:     state_next = slp_pkg::S_DEL_B;
            slp_pkg::S_DEL_B:     state_next = slp_pkg::S_DEL_C;
            slp_pkg::S_DEL_C:     state_next = slp_pkg::S_DEL_D;
            slp_pkg::S_DEL_D:     state_next = slp_pkg::S_DONE;
            slp_pkg::S_CLR_A:
                state_next = sts.link_zero ? slp_pkg::S_DONE : slp_pkg::S_CLR_B;
            slp_pkg::S_CLR_B:     state_next = slp_pkg::S_CLR_C;
            slp_pkg::S_CLR_C:     state_next = slp_pkg::S_CLR_D;
            slp_pkg::S_CLR_D:     state_next = slp_pkg::S_TAIL_WALK;
            slp_pkg::S_TAIL_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = slp_pkg::S_DONE;
                end
            end
            slp_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = slp_pkg::S_IDLE;
                end
            end
            default:              state_next = slp_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            slp_pkg::S_INIT:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_CNT;
                cmd.wd_sel = slp_pkg::WD_INIT;
                cmd.cnt_op = slp_pkg::CNT_INC;
            end
            slp_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            slp_pkg::S_DISPATCH:
            begin
                case (kind_reg)
                    slp_pkg::KIND_NEW:
                        cmd.ra_sel = slp_pkg::RA_ZERO;
                    slp_pkg::KIND_INSERT, slp_pkg::KIND_DELETE,
                    slp_pkg::KIND_GET, slp_pkg::KIND_LENGTH, slp_pkg::KIND_CLEAR:
                    begin
                        cmd.ra_sel      = slp_pkg::RA_HEAD;
                        cmd.cur_sel     = slp_pkg::CUR_HEAD;
                        cmd.cnt_op      = slp_pkg::CNT_CLEAR;
                        cmd.set_status  = sts.head_bad;
                        cmd.status_code = slp_pkg::STS_RANGE;
                    end
                    default:
                        cmd.ra_sel = slp_pkg::RA_LINK;
                endcase
            end
            slp_pkg::S_LEN_WALK:
            begin
                if (walk_more)
                begin
                    cmd.ra_sel  = slp_pkg::RA_LINK;
                    cmd.cur_sel = slp_pkg::CUR_LINK;
                    cmd.cnt_op  = slp_pkg::CNT_INC;
                end
                else
                begin
                    case (kind_reg)
                        slp_pkg::KIND_INSERT:
                        begin
                            cmd.ra_sel      = slp_pkg::RA_ZERO;
                            cmd.set_status  = sts.pos_zero || sts.pos_gt_len1;
                            cmd.status_code = slp_pkg::STS_RANGE;
                        end
                        slp_pkg::KIND_DELETE, slp_pkg::KIND_GET:
                        begin
                            cmd.ra_sel     = slp_pkg::RA_HEAD;
                            cmd.cur_sel    = slp_pkg::CUR_HEAD;
                            cmd.cnt_op     = slp_pkg::CNT_CLEAR;
                            // an empty list is reported ahead of a bad position
                            if (sts.cnt_zero)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = slp_pkg::STS_EMPTY;
                            end
                            else if (sts.pos_zero || sts.pos_gt_len)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = slp_pkg::STS_RANGE;
                            end
                        end
                        default:
                            cmd.set_length = 1'b1;
                    endcase
                end
            end
            slp_pkg::S_STEP_WALK:
            begin
                if (!at_target)
                begin
                    cmd.ra_sel  = slp_pkg::RA_LINK;
                    cmd.cur_sel = slp_pkg::CUR_LINK;
                    cmd.cnt_op  = slp_pkg::CNT_INC;
                end
                else
                begin
                    // delete: keep the victim and fetch its successor
                    cmd.ra_sel = slp_pkg::RA_LINK;
                    cmd.k_load = 1'b1;
                end
            end
            slp_pkg::S_GET_A:
                cmd.set_read = 1'b1;
            slp_pkg::S_NEW_A:
            begin
                cmd.ra_sel      = slp_pkg::RA_LINK;
                cmd.j_load      = 1'b1;
                cmd.set_status  = sts.link_zero;
                cmd.status_code = slp_pkg::STS_EXHAUSTED;
            end
            slp_pkg::S_NEW_B:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_ZERO;
                cmd.wd_sel = slp_pkg::WD_LINK;
            end
            slp_pkg::S_NEW_C:
            begin
                cmd.nx_we        = 1'b1;
                cmd.wa_sel       = slp_pkg::WA_J;
                cmd.wd_sel       = slp_pkg::WD_ZERO;
                cmd.set_new_head = 1'b1;
            end
            slp_pkg::S_INS_A:
            begin
                cmd.ra_sel      = slp_pkg::RA_LINK;
                cmd.j_load      = 1'b1;
                cmd.set_status  = sts.link_zero;
                cmd.status_code = slp_pkg::STS_EXHAUSTED;
            end
            slp_pkg::S_INS_B:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_ZERO;
                cmd.wd_sel = slp_pkg::WD_LINK;
                cmd.val_we = 1'b1;
            end
            slp_pkg::S_INS_C:
            begin
                cmd.ra_sel  = slp_pkg::RA_HEAD;
                cmd.cur_sel = slp_pkg::CUR_HEAD;
                cmd.cnt_op  = slp_pkg::CNT_CLEAR;
            end
            slp_pkg::S_INS_WALK:
            begin
                if (!sts.cnt_eq_posm1)
                begin
                    cmd.ra_sel  = slp_pkg::RA_LINK;
                    cmd.cur_sel = slp_pkg::CUR_LINK;
                    cmd.cnt_op  = slp_pkg::CNT_INC;
                end
                else
                begin
                    cmd.nx_we  = 1'b1;
                    cmd.wa_sel = slp_pkg::WA_J;
                    cmd.wd_sel = slp_pkg::WD_LINK;
                end
            end
            slp_pkg::S_INS_D:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_CUR;
                cmd.wd_sel = slp_pkg::WD_J;
            end
            slp_pkg::S_DEL_A:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_CUR;
                cmd.wd_sel = slp_pkg::WD_LINK;
            end
            slp_pkg::S_DEL_B:
                cmd.ra_sel = slp_pkg::RA_ZERO;
            slp_pkg::S_DEL_C:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_K;
                cmd.wd_sel = slp_pkg::WD_LINK;
            end
            slp_pkg::S_DEL_D:
            begin
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_ZERO;
                cmd.wd_sel = slp_pkg::WD_K;
            end
            slp_pkg::S_CLR_A:
            begin
                cmd.j_load = 1'b1;
                cmd.nx_we  = !sts.link_zero;
                cmd.wa_sel = slp_pkg::WA_HEAD;
                cmd.wd_sel = slp_pkg::WD_ZERO;
            end
            slp_pkg::S_CLR_B:
                cmd.ra_sel = slp_pkg::RA_ZERO;
            slp_pkg::S_CLR_C:
            begin
                cmd.k_load = 1'b1;
                cmd.nx_we  = 1'b1;
                cmd.wa_sel = slp_pkg::WA_ZERO;
                cmd.wd_sel = slp_pkg::WD_J;
            end
            slp_pkg::S_CLR_D:
            begin
                cmd.ra_sel  = slp_pkg::RA_J;
                cmd.cur_sel = slp_pkg::CUR_J;
                cmd.cnt_op  = slp_pkg::CNT_CLEAR;
            end
            slp_pkg::S_TAIL_WALK:
            begin
                if (walk_more)
                begin
                    cmd.ra_sel  = slp_pkg::RA_LINK;
                    cmd.cur_sel = slp_pkg::CUR_LINK;
                    cmd.cnt_op  = slp_pkg::CNT_INC;
                end
                else
                begin
                    // old free chain goes behind the released tail
                    cmd.nx_we  = 1'b1;
                    cmd.wa_sel = slp_pkg::WA_CUR;
                    cmd.wd_sel = slp_pkg::WD_K;
                end
            end
            slp_pkg::S_DONE:
                cmd.publish = out_free;
            default:
                cmd.ra_sel = slp_pkg::RA_LINK;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slp_pkg::S_INIT;
            out_valid_reg <= 1'b0;
            kind_reg      <= slp_pkg::KIND_NEW;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                kind_reg <= slp_pkg::kind_t'(kind);
            end
        end
    end

    assign out_valid = out_valid_reg;

    // a result appears only out of the completion state
    a_publish_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == slp_pkg::S_DONE))
        else $error("result raised outside completion state");

    // no link update while waiting for a request
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slp_pkg::S_IDLE) |-> !cmd.nx_we && !cmd.val_we)
        else $error("pool written while idle");

    // length walk stops once the link bound is reached
    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slp_pkg::S_LEN_WALK) && sts.cnt_full
        |=> state_reg != slp_pkg::S_LEN_WALK)
        else $error("length walk ran past the pool size");

    // reset sweep runs once
    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != slp_pkg::S_INIT) |=> state_reg != slp_pkg::S_INIT)
        else $error("reset sweep re-entered");

endmodule

FILE: hw/rtl/static_linked_list_pool_top.sv
// ----------------------------------------------------------------------------
// static_linked_list_pool_top
// Node pool shared by several singly linked lists, with a free chain at node 0.
// ----------------------------------------------------------------------------
// After reset the block sweeps all NODES (128) entries of the link memory and
// accepts no request until the sweep is done. A request with a bad head or
// an unknown kind ends soonest and a new list needs no walk; the longest
// requests are an insert, delete or get at the far end of a chain that runs
// through the whole pool: every walk follows one link per cycle through the
// single read port of the link memory, and insert, delete and get walk the
// list twice, once to count it and once to reach the position. One request is
// in work at a time; a finished result sits in the output register, so the
// next request is taken while it waits.
module static_linked_list_pool_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [slp_pkg::KIND_W-1:0]          kind,
    input  logic [slp_pkg::NODE_W-1:0]          list_head,
    input  logic [slp_pkg::POS_W-1:0]           position,
    input  logic signed [slp_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [slp_pkg::STATUS_W-1:0]        status,
    output logic [slp_pkg::NODE_W-1:0]          new_head,
    output logic signed [slp_pkg::VALUE_W-1:0]  read_value,
    output logic [slp_pkg::LEN_W-1:0]           length
);

    slp_pkg::slp_cmd_t cmd;
    slp_pkg::slp_sts_t sts;

    slp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    slp_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .list_head  (list_head),
        .position   (position),
        .value      (value),
        .status     (status),
        .new_head   (new_head),
        .read_value (read_value),
        .length     (length)
    );

endmodule
